/* design/ppb_pkg.sv */
// ----------------------------------------------------------------------------
// ppb_pkg: shared types and constants of the particle pusher
// Field widths, register indexes, boundary modes, status codes, the queue
// entry and the back-end state type.
// ----------------------------------------------------------------------------
package ppb_pkg;

   localparam int DATA_W      = 32;
   localparam int STEP_W      = 31;
   localparam int CCOUNT_W    = 13;
   localparam int CELLS_W     = 17;
   localparam int CELL_W      = 12;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_STEP   = 3'd0,
      CSR_LOWER_EDGE  = 3'd1,
      CSR_UPPER_EDGE  = 3'd2,
      CSR_INV_WIDTH   = 3'd3,
      CSR_CELL_COUNT  = 3'd4,
      CSR_BOUND_MODE  = 3'd5
   } csr_index_type;

   localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REFLECT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABOVE      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FOLD_LIMIT = 2'd3;

   typedef struct packed {
      logic        [STEP_W-1:0]   time_step;
      logic signed [DATA_W-1:0]   lower_edge;
      logic signed [DATA_W-1:0]   upper_edge;
      logic        [STEP_W-1:0]   inverse_cell_width;
      logic        [CCOUNT_W-1:0] cell_count;
      logic        [MODE_W-1:0]   boundary_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
   } push_item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_FOLD,
      B_CLASSIFY,
      B_SCALE,
      B_DONE
   } back_state_type;

endpackage

/* design/ppb_front.sv */
// ----------------------------------------------------------------------------
// ppb_front: Euler push front end
// Takes a particle beat, forms dt*v and dt*E, then floors, adds and
// saturates them into the pushed position and velocity for the queue.
// ----------------------------------------------------------------------------
module ppb_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [ppb_pkg::DATA_W-1:0] req_position,
   input  logic signed [ppb_pkg::DATA_W-1:0] req_velocity_x,
   input  logic signed [ppb_pkg::DATA_W-1:0] req_field,
   input  logic        [ppb_pkg::STEP_W-1:0] time_step,
   input  logic                           q_full,
   output logic                           q_push,
   output ppb_pkg::push_item_type         q_item
);

   localparam int PROD_W = 64;
   localparam int SUM_W  = PROD_W - FRAC_BITS + 1;
   localparam int DW     = ppb_pkg::DATA_W;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DW-1:0]     pos_ff, vel_ff;
   logic signed [PROD_W-1:0] prod_v_ff, prod_e_ff;
   logic signed [PROD_W-1:0] step_v, step_e;
   logic signed [SUM_W-1:0]  pos_sum, vel_sum;
   logic                     accept;

   function automatic logic signed [DW-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
      logic signed [DW-1:0] r;
      if ((s[SUM_W-1:DW-1] == '0) || (s[SUM_W-1:DW-1] == '1)) begin
         r = s[DW-1:0];
      end else if (s[SUM_W-1]) begin
         r = {1'b1, {(DW-1){1'b0}}};
      end else begin
         r = {1'b0, {(DW-1){1'b1}}};
      end
      return r;
   endfunction

   assign req_stall = s1_valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = s1_valid_ff & ~q_full;

   always_comb begin
      s1_valid_in = accept | (s1_valid_ff & q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff    <= req_position;
         vel_ff    <= req_velocity_x;
         prod_v_ff <= PROD_W'(req_velocity_x) * PROD_W'($signed({1'b0, time_step}));
         prod_e_ff <= PROD_W'(req_field) * PROD_W'($signed({1'b0, time_step}));
      end
   end

   always_comb begin
      step_v          = prod_v_ff >>> FRAC_BITS;
      step_e          = prod_e_ff >>> FRAC_BITS;
      pos_sum         = SUM_W'(pos_ff) + step_v[SUM_W-1:0];
      vel_sum         = SUM_W'(vel_ff) + step_e[SUM_W-1:0];
      q_item.position = sat_sum(pos_sum);
      q_item.velocity = sat_sum(vel_sum);
   end

endmodule

/* design/ppb_queue.sv */
// ----------------------------------------------------------------------------
// ppb_queue: short queue between front end and back end
// Holds pushed particles so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ppb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ppb_pkg::push_item_type item_in,
   input  logic                   pop,
   output ppb_pkg::push_item_type item_out,
   output logic                   full,
   output logic                   empty
);

   localparam int DEPTH = ppb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = ppb_pkg::QPTR_W;
   localparam int CNT_W = ppb_pkg::QCNT_W;

   ppb_pkg::push_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign item_out = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* design/ppb_back.sv */
// ----------------------------------------------------------------------------
// ppb_back: boundary folding and cell binning back end
// Takes one particle at a time, folds it at the walls, classifies the final
// position, scales its offset into a cell index and holds the result beat.
// ----------------------------------------------------------------------------
module ppb_back #(
   parameter int MAX_FOLDS = 4,
   parameter int MAX_CELLS = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ppb_pkg::cfg_type                 cfg,
   input  logic                             q_empty,
   input  ppb_pkg::push_item_type           q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ppb_pkg::DATA_W-1:0] rsp_new_position,
   output logic signed [ppb_pkg::DATA_W-1:0] rsp_new_velocity_x,
   output logic        [ppb_pkg::CELL_W-1:0] rsp_cell_index,
   output logic        [ppb_pkg::STATUS_W-1:0] rsp_status
);

   localparam int DW     = ppb_pkg::DATA_W;
   localparam int CNT_W  = $clog2(MAX_FOLDS + 1);
   localparam int PW     = 34 + CNT_W;
   localparam int OFF_W  = 33;
   localparam int PROD_W = 64;
   localparam int G_W    = PROD_W - FRAC_BITS;
   localparam int CW     = ppb_pkg::CELLS_W;
   localparam int XW     = ppb_pkg::CELL_W;
   localparam int SW     = ppb_pkg::STATUS_W;

   ppb_pkg::back_state_type state_ff, state_in;

   logic signed [PW-1:0]     pos_ff;
   logic signed [DW-1:0]     vel_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     last_upper_ff, settled_ff;
   logic [SW-1:0]            status_ff;
   logic [XW-1:0]            cell_ff;
   logic [OFF_W-1:0]         off_ff;
   logic                     scale_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     rsp_valid_ff;
   logic signed [DW-1:0]     rsp_pos_ff, rsp_vel_ff;
   logic [XW-1:0]            rsp_cell_ff;
   logic [SW-1:0]            rsp_status_ff;

   logic signed [PW-1:0] lo_w, hi_w, period, fold_pos;
   logic signed [DW-1:0] vel_neg;
   logic [PW-1:0]        off_full;
   logic                 above, below, folding_mode, reflect_mode;
   logic                 settled_now, fold_stop, off_big;
   logic [CW-1:0]        cells_raw, cells_eff;
   logic [G_W-1:0]       g;
   logic                 g_over;
   logic [SW-1:0]        fin_status;
   logic [XW-1:0]        fin_cell;
   logic                 out_free;
   logic                 load_item, fold_en, fold_exit, classify_en, scale_en, out_load;

   function automatic logic signed [DW-1:0] sat_pos(input logic signed [PW-1:0] s);
      logic signed [DW-1:0] r;
      if ((s[PW-1:DW-1] == '0) || (s[PW-1:DW-1] == '1)) begin
         r = s[DW-1:0];
      end else if (s[PW-1]) begin
         r = {1'b1, {(DW-1){1'b0}}};
      end else begin
         r = {1'b0, {(DW-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      lo_w         = PW'(cfg.lower_edge);
      hi_w         = PW'(cfg.upper_edge);
      period       = hi_w - lo_w;
      above        = (pos_ff >= hi_w);
      below        = (pos_ff < lo_w);
      folding_mode = (cfg.boundary_mode == ppb_pkg::MODE_PERIODIC) ||
                     (cfg.boundary_mode == ppb_pkg::MODE_REFLECT);
      reflect_mode = (cfg.boundary_mode == ppb_pkg::MODE_REFLECT);
      settled_now  = reflect_mode && last_upper_ff && (pos_ff == hi_w);
      fold_stop    = settled_now || (count_ff == CNT_W'(MAX_FOLDS)) || !(above || below);
      if (reflect_mode) begin
         fold_pos = above ? ((hi_w <<< 1) - pos_ff) : ((lo_w <<< 1) - pos_ff);
      end else begin
         fold_pos = above ? (pos_ff - period) : (pos_ff + period);
      end
      vel_neg  = (vel_ff == {1'b1, {(DW-1){1'b0}}}) ? {1'b0, {(DW-1){1'b1}}} : -vel_ff;
      off_full = pos_ff - lo_w;
      off_big  = |off_full[PW-1:OFF_W];
   end

   always_comb begin
      cells_raw = CW'(cfg.cell_count);
      if (cells_raw == '0) begin
         cells_eff = CW'(1);
      end else if (cells_raw > CW'(MAX_CELLS)) begin
         cells_eff = CW'(MAX_CELLS);
      end else begin
         cells_eff = cells_raw;
      end
      g      = prod_ff[PROD_W-1:FRAC_BITS];
      g_over = (g >= G_W'(cells_eff));
      if (scale_ff) begin
         fin_status = g_over ? ppb_pkg::ST_ABOVE : ppb_pkg::ST_OK;
         fin_cell   = g_over ? '0 : g[XW-1:0];
      end else begin
         fin_status = status_ff;
         fin_cell   = cell_ff;
      end
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppb_pkg::B_IDLE: begin
            if (!q_empty) begin
               state_in = (cfg.boundary_mode == ppb_pkg::MODE_PERIODIC ||
                           cfg.boundary_mode == ppb_pkg::MODE_REFLECT) ?
                          ppb_pkg::B_FOLD : ppb_pkg::B_CLASSIFY;
            end
         end
         ppb_pkg::B_FOLD: begin
            if (fold_stop) begin
               state_in = ppb_pkg::B_CLASSIFY;
            end
         end
         ppb_pkg::B_CLASSIFY: begin
            if (below || (pos_ff == hi_w) || off_big ||
                (folding_mode && !settled_ff && above)) begin
               state_in = ppb_pkg::B_DONE;
            end else begin
               state_in = ppb_pkg::B_SCALE;
            end
         end
         ppb_pkg::B_SCALE: begin
            state_in = ppb_pkg::B_DONE;
         end
         ppb_pkg::B_DONE: begin
            if (out_free) begin
               state_in = ppb_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = ppb_pkg::B_IDLE;
         end
      endcase
   end

   always_comb begin
      load_item   = 1'b0;
      fold_en     = 1'b0;
      fold_exit   = 1'b0;
      classify_en = 1'b0;
      scale_en    = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         ppb_pkg::B_IDLE:     load_item   = ~q_empty;
         ppb_pkg::B_FOLD: begin
            fold_en   = ~fold_stop;
            fold_exit = fold_stop;
         end
         ppb_pkg::B_CLASSIFY: classify_en = 1'b1;
         ppb_pkg::B_SCALE:    scale_en    = 1'b1;
         ppb_pkg::B_DONE:     out_load    = out_free;
         default: begin
            load_item = 1'b0;
         end
      endcase
   end

   assign q_pop = load_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppb_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_item) begin
         pos_ff        <= PW'(q_item.position);
         vel_ff        <= q_item.velocity;
         count_ff      <= '0;
         last_upper_ff <= 1'b0;
         settled_ff    <= 1'b0;
      end
      if (fold_en) begin
         pos_ff        <= fold_pos;
         vel_ff        <= reflect_mode ? vel_neg : vel_ff;
         count_ff      <= count_ff + CNT_W'(1);
         last_upper_ff <= above;
      end
      if (fold_exit) begin
         settled_ff <= settled_now;
      end
      if (classify_en) begin
         scale_ff  <= 1'b0;
         cell_ff   <= '0;
         off_ff    <= off_full[OFF_W-1:0];
         if (folding_mode && !settled_ff && (above || below)) begin
            status_ff <= ppb_pkg::ST_FOLD_LIMIT;
         end else if (below) begin
            status_ff <= ppb_pkg::ST_BELOW;
         end else if (pos_ff == hi_w) begin
            status_ff <= ppb_pkg::ST_OK;
            cell_ff   <= XW'(cells_eff - CW'(1));
         end else if (off_big) begin
            status_ff <= ppb_pkg::ST_ABOVE;
         end else begin
            status_ff <= ppb_pkg::ST_OK;
            scale_ff  <= 1'b1;
         end
      end
      if (scale_en) begin
         prod_ff <= PROD_W'(off_ff) * PROD_W'(cfg.inverse_cell_width);
      end
      if (out_load) begin
         rsp_pos_ff    <= sat_pos(pos_ff);
         rsp_vel_ff    <= vel_ff;
         rsp_cell_ff   <= fin_cell;
         rsp_status_ff <= fin_status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_position   = rsp_pos_ff;
   assign rsp_new_velocity_x = rsp_vel_ff;
   assign rsp_cell_index     = rsp_cell_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

/* design/particle_push_with_boundaries.sv */
// ----------------------------------------------------------------------------
// particle_push_with_boundaries: explicit Euler particle push with walls
// A request beat carries position, x velocity and local field (Q16.16).
// The front end forms x + dt*v and v + dt*E in one registered multiply
// stage and writes the pair into a two-entry queue. The back end folds the
// position at the walls (none, periodic or mirror, mirror negating the
// velocity), one fold a cycle up to MAX_FOLDS, then bins it into a cell.
// The back end works on one particle at a time and so sets the throughput.
// The response beat sits in an output register, so the block keeps taking
// requests into the queue while rsp_stall is high; req_stall rises once the
// queue and the front stage are full. Reset clears all beats in flight and
// loads the register defaults. The user must write registers through csr_*
// only while no beat is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module particle_push_with_boundaries #(
   parameter int MAX_FOLDS = 4,
   parameter int MAX_CELLS = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ppb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppb_pkg::DATA_W-1:0]          csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ppb_pkg::DATA_W-1:0]   req_position,
   input  logic signed [ppb_pkg::DATA_W-1:0]   req_velocity_x,
   input  logic signed [ppb_pkg::DATA_W-1:0]   req_field,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ppb_pkg::DATA_W-1:0]   rsp_new_position,
   output logic signed [ppb_pkg::DATA_W-1:0]   rsp_new_velocity_x,
   output logic        [ppb_pkg::CELL_W-1:0]   rsp_cell_index,
   output logic        [ppb_pkg::STATUS_W-1:0] rsp_status
);

   ppb_pkg::cfg_type       cfg_ff;
   ppb_pkg::push_item_type q_in_item, q_out_item;
   logic                   q_push, q_pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step          <= '0;
         cfg_ff.lower_edge         <= '0;
         cfg_ff.upper_edge         <= 32'sd65536;
         cfg_ff.inverse_cell_width <= 31'd65536;
         cfg_ff.cell_count         <= 13'd1;
         cfg_ff.boundary_mode      <= ppb_pkg::MODE_OPEN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ppb_pkg::CSR_TIME_STEP:
               cfg_ff.time_step <= csr_write_data[ppb_pkg::STEP_W-1:0];
            ppb_pkg::CSR_LOWER_EDGE:
               cfg_ff.lower_edge <= $signed(csr_write_data);
            ppb_pkg::CSR_UPPER_EDGE:
               cfg_ff.upper_edge <= $signed(csr_write_data);
            ppb_pkg::CSR_INV_WIDTH:
               cfg_ff.inverse_cell_width <= csr_write_data[ppb_pkg::STEP_W-1:0];
            ppb_pkg::CSR_CELL_COUNT:
               cfg_ff.cell_count <= csr_write_data[ppb_pkg::CCOUNT_W-1:0];
            ppb_pkg::CSR_BOUND_MODE:
               cfg_ff.boundary_mode <= csr_write_data[ppb_pkg::MODE_W-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   ppb_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_position   (req_position),
      .req_velocity_x (req_velocity_x),
      .req_field      (req_field),
      .time_step      (cfg_ff.time_step),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_in_item)
   );

   ppb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_in_item),
      .pop      (q_pop),
      .item_out (q_out_item),
      .full     (q_full),
      .empty    (q_empty)
   );

   ppb_back #(
      .MAX_FOLDS (MAX_FOLDS),
      .MAX_CELLS (MAX_CELLS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_item             (q_out_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_new_position   (rsp_new_position),
      .rsp_new_velocity_x (rsp_new_velocity_x),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_status         (rsp_status)
   );

endmodule
